### rtl/core/prtb_pkg.sv
// shared constants and types for the point transform and bounding box block
package prtb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH = 16;
  localparam int NUM_AXES = 3;
  localparam int CFG_IDX_WIDTH = 3;

  // offset register reset values in Q16.16 (0.45 m and 1.5 m)
  localparam int OFFSET_X_RESET = 29491;
  localparam int OFFSET_Y_RESET = 0;
  localparam int OFFSET_Z_RESET = 98304;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ROW_X,
    CFG_ROW_Y,
    CFG_ROW_Z,
    CFG_OFF_X,
    CFG_OFF_Y,
    CFG_OFF_Z
  } prtb_cfg_idx_e;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } prtb_stage_en_t;

endpackage

### rtl/core/prtb_in_if.sv
// input point channel: valid/ready with one point and its cloud end flag
interface prtb_in_if #(
  parameter int COORD_WIDTH = prtb_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;
  logic                          cloud_end;

  modport source (output valid, in_x, in_y, in_z, cloud_end, input ready);
  modport sink (input valid, in_x, in_y, in_z, cloud_end, output ready);
endinterface

### rtl/core/prtb_out_if.sv
// result channel: transformed point plus bounding box so far
interface prtb_out_if #(
  parameter int COORD_WIDTH = prtb_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic                          cloud_done;

  modport source (
    output valid, out_x, out_y, out_z, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, cloud_done,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, cloud_done,
    output ready
  );
endinterface

### rtl/core/prtb_row.sv
// one matrix row: registered products, then sum, floor shift, offset and saturate
module prtb_row #(
  parameter int COORD_WIDTH = prtb_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = prtb_pkg::COEF_WIDTH
) (
  input  logic                          clk_i,
  input  prtb_pkg::prtb_stage_en_t      en_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  input  logic [3*COEF_WIDTH-1:0]       coef_i,
  input  logic signed [COORD_WIDTH-1:0] offset_i,
  output logic signed [COORD_WIDTH-1:0] res_o
);

  localparam int ProdW = COORD_WIDTH + COEF_WIDTH;
  localparam int SumW  = ProdW + 2;
  localparam int Frac  = COEF_WIDTH - 2;
  localparam int ShW   = SumW - Frac;
  localparam int TotW  = ShW + 1;

  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [ProdW-1:0]       prod_d [3];
  logic signed [ProdW-1:0]       prod_q [3];
  logic signed [SumW-1:0]        sum;
  logic signed [TotW-1:0]        total;
  logic                          fits;
  logic signed [COORD_WIDTH-1:0] res_d;
  logic signed [COORD_WIDTH-1:0] res_q;

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = ProdW'(pt[k]) * ProdW'($signed(coef_i[k*COEF_WIDTH +: COEF_WIDTH]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift by the fraction bits is a floor
  always_comb begin
    sum   = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]);
    total = TotW'($signed(sum[SumW-1:Frac])) + TotW'(offset_i);
    fits  = (total[TotW-1:COORD_WIDTH-1] == '0) || (total[TotW-1:COORD_WIDTH-1] == '1);
    if (fits) begin
      res_d = total[COORD_WIDTH-1:0];
    end else if (total[TotW-1]) begin
      res_d = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/point_rotate_translate_bbox_core.sv
// top level: rigid 3d transform of a point stream with a running bounding box
//
// in_i carries one point per beat (x, y, z in signed Q16.16, cloud_end flag).
// Each point is multiplied by the configured 3x3 matrix of Q2.14 coefficients,
// floor-shifted, offset and saturated, then folded into the per-axis min/max.
// out_o beats carry the transformed point, the box including that point and
// cloud_done; after a cloud_end beat the box starts empty again.
// An input beat passes through the product registers, the transformed point
// registers and the output register with box update before its result beat.
// Throughput is one beat per cycle while the receiver does not stall; the nine
// 32x16 products are the widest path and sit alone in the first stage.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so bubbles close up and in_i.ready drops once all three are full.
// Reset empties the pipeline, loads the identity matrix with offsets
// 0.45 m / 0 / 1.5 m and clears the box. Config writes go through cfg_we_i,
// cfg_idx_i and cfg_data_i and must come while no beat is in flight.
module point_rotate_translate_bbox_core #(
  parameter int COORD_WIDTH = prtb_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = prtb_pkg::COEF_WIDTH,
  localparam int RowW = 3 * COEF_WIDTH,
  localparam int CfgW = (RowW > COORD_WIDTH) ? RowW : COORD_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [prtb_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]                  cfg_data_i,
  prtb_in_if.sink                          in_i,
  prtb_out_if.source                       out_o
);

  localparam int NAx = prtb_pkg::NUM_AXES;
  localparam logic signed [COORD_WIDTH-1:0] MaxV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MinV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [RowW-1:0]               coef_q [NAx];
  logic signed [COORD_WIDTH-1:0] off_q [NAx];

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic last1_q, last2_q, last3_q;
  logic load3;
  prtb_pkg::prtb_stage_en_t en;

  logic signed [COORD_WIDTH-1:0] tr [NAx];
  logic signed [COORD_WIDTH-1:0] run_min_q [NAx];
  logic signed [COORD_WIDTH-1:0] run_max_q [NAx];
  logic signed [COORD_WIDTH-1:0] min_d [NAx];
  logic signed [COORD_WIDTH-1:0] max_d [NAx];
  logic signed [COORD_WIDTH-1:0] pt_q [NAx];
  logic signed [COORD_WIDTH-1:0] min_q [NAx];
  logic signed [COORD_WIDTH-1:0] max_q [NAx];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NAx; k++) begin
        coef_q[k] <= RowW'(1) << (k * COEF_WIDTH + COEF_WIDTH - 2);
      end
      off_q[0] <= COORD_WIDTH'(prtb_pkg::OFFSET_X_RESET);
      off_q[1] <= COORD_WIDTH'(prtb_pkg::OFFSET_Y_RESET);
      off_q[2] <= COORD_WIDTH'(prtb_pkg::OFFSET_Z_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prtb_pkg::CFG_ROW_X: coef_q[0] <= cfg_data_i[RowW-1:0];
        prtb_pkg::CFG_ROW_Y: coef_q[1] <= cfg_data_i[RowW-1:0];
        prtb_pkg::CFG_ROW_Z: coef_q[2] <= cfg_data_i[RowW-1:0];
        prtb_pkg::CFG_OFF_X: off_q[0] <= cfg_data_i[COORD_WIDTH-1:0];
        prtb_pkg::CFG_OFF_Y: off_q[1] <= cfg_data_i[COORD_WIDTH-1:0];
        prtb_pkg::CFG_OFF_Z: off_q[2] <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // a stage may take a new beat when it is empty or its beat moves on
  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign en.mul_en = in_i.valid && rdy1;
  assign en.sum_en = v1_q && rdy2;
  assign load3 = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.mul_en) last1_q <= in_i.cloud_end;
    if (en.sum_en) last2_q <= last1_q;
    if (load3) last3_q <= last2_q;
  end

  for (genvar g = 0; g < NAx; g++) begin : g_row
    prtb_row #(
      .COORD_WIDTH(COORD_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_row (
      .clk_i   (clk_i),
      .en_i    (en),
      .x_i     (in_i.in_x),
      .y_i     (in_i.in_y),
      .z_i     (in_i.in_z),
      .coef_i  (coef_q[g]),
      .offset_i(off_q[g]),
      .res_o   (tr[g])
    );
  end

  always_comb begin
    for (int k = 0; k < NAx; k++) begin
      min_d[k] = (tr[k] < run_min_q[k]) ? tr[k] : run_min_q[k];
      max_d[k] = (tr[k] > run_max_q[k]) ? tr[k] : run_max_q[k];
    end
  end

  // running box, emptied after the last point of a cloud
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NAx; k++) begin
        run_min_q[k] <= MaxV;
        run_max_q[k] <= MinV;
      end
    end else if (load3) begin
      for (int k = 0; k < NAx; k++) begin
        run_min_q[k] <= last2_q ? MaxV : min_d[k];
        run_max_q[k] <= last2_q ? MinV : max_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load3) begin
      pt_q  <= tr;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign out_o.valid      = v3_q;
  assign out_o.out_x      = pt_q[0];
  assign out_o.out_y      = pt_q[1];
  assign out_o.out_z      = pt_q[2];
  assign out_o.box_min_x  = min_q[0];
  assign out_o.box_min_y  = min_q[1];
  assign out_o.box_min_z  = min_q[2];
  assign out_o.box_max_x  = max_q[0];
  assign out_o.box_max_y  = max_q[1];
  assign out_o.box_max_z  = max_q[2];
  assign out_o.cloud_done = last3_q;

endmodule

### dv/point_rotate_translate_bbox_core_test.sv
`timescale 1ns / 1ps
// self-checking test of the point transform and bounding box core
module point_rotate_translate_bbox_core_test;

  localparam int COORD_WIDTH = prtb_pkg::COORD_WIDTH;
  localparam int COEF_WIDTH = prtb_pkg::COEF_WIDTH;
  localparam int CFG_IDX_WIDTH = prtb_pkg::CFG_IDX_WIDTH;
  localparam int CFG_W = (3 * COEF_WIDTH > COORD_WIDTH) ? 3 * COEF_WIDTH : COORD_WIDTH;
  localparam int FRAC_BITS = COEF_WIDTH - 2;
  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 200;
  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << FRAC_BITS);
  localparam logic [COEF_WIDTH-1:0] COEF_HALF = COEF_WIDTH'(1 << (FRAC_BITS - 1));
  localparam logic [COEF_WIDTH-1:0] COEF_NEG_TWO = COEF_WIDTH'(1 << (COEF_WIDTH - 1));
  localparam logic [COEF_WIDTH-1:0] COEF_TOP = COEF_WIDTH'((1 << (COEF_WIDTH - 1)) - 1);
  // indexes past the last register, writes to them must be dropped
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_B = 3'd7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t pt_x, pt_y, pt_z;
    coord_t lo_x, lo_y, lo_z;
    coord_t hi_x, hi_y, hi_z;
    logic   done;
  } point_box_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  prtb_in_if  in_if ();
  prtb_out_if out_if ();

  point_rotate_translate_bbox_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // shadow copy of the registers and the running box
  logic [3*COEF_WIDTH-1:0] coef_row [3] = '{
    {16'h0000, 16'h0000, COEF_ONE},
    {16'h0000, COEF_ONE, 16'h0000},
    {COEF_ONE, 16'h0000, 16'h0000}
  };
  coord_t offset [3] = '{prtb_pkg::OFFSET_X_RESET, prtb_pkg::OFFSET_Y_RESET,
                         prtb_pkg::OFFSET_Z_RESET};
  coord_t box_lo [3] = '{coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX)};
  coord_t box_hi [3] = '{coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN)};

  point_box_t point_box_q [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int cloud_left = 1;
  bit src_idle_on = 1'b0;
  bit sink_stall_on = 1'b0;
  int long_hold_req = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic coord_t rotate_axis(logic [3*COEF_WIDTH-1:0] row, coord_t px, coord_t py,
                                         coord_t pz, coord_t off);
    longint acc;
    acc = longint'($signed(row[COEF_WIDTH-1:0])) * longint'(px)
        + longint'($signed(row[2*COEF_WIDTH-1:COEF_WIDTH])) * longint'(py)
        + longint'($signed(row[3*COEF_WIDTH-1:2*COEF_WIDTH])) * longint'(pz);
    // arithmetic shift gives the floor
    acc = (acc >>> FRAC_BITS) + longint'(off);
    if (acc > COORD_MAX) acc = COORD_MAX;
    if (acc < COORD_MIN) acc = COORD_MIN;
    return coord_t'(acc);
  endfunction

  function automatic void predict_point_box(coord_t px, coord_t py, coord_t pz, logic last);
    point_box_t r;
    coord_t t [3];
    for (int a = 0; a < 3; a++) begin
      t[a] = rotate_axis(coef_row[a], px, py, pz, offset[a]);
      if (t[a] < box_lo[a]) box_lo[a] = t[a];
      if (t[a] > box_hi[a]) box_hi[a] = t[a];
    end
    r.pt_x = t[0];  r.pt_y = t[1];  r.pt_z = t[2];
    r.lo_x = box_lo[0];  r.lo_y = box_lo[1];  r.lo_z = box_lo[2];
    r.hi_x = box_hi[0];  r.hi_y = box_hi[1];  r.hi_z = box_hi[2];
    r.done = last;
    point_box_q.push_back(r);
    if (last) begin
      box_lo = '{coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX)};
      box_hi = '{coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN)};
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [COORD_WIDTH-1:0] got,
                             logic [COORD_WIDTH-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin : check_results
    point_box_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (point_box_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = point_box_q.pop_front();
        check_field("out_x", out_if.out_x, want.pt_x);
        check_field("out_y", out_if.out_y, want.pt_y);
        check_field("out_z", out_if.out_z, want.pt_z);
        check_field("box_min_x", out_if.box_min_x, want.lo_x);
        check_field("box_min_y", out_if.box_min_y, want.lo_y);
        check_field("box_min_z", out_if.box_min_z, want.lo_z);
        check_field("box_max_x", out_if.box_max_x, want.hi_x);
        check_field("box_max_y", out_if.box_max_y, want.hi_y);
        check_field("box_max_z", out_if.box_max_z, want.hi_z);
        if (out_if.cloud_done !== want.done) begin
          report_mismatch($sformatf("cloud_done got %b want %b", out_if.cloud_done, want.done));
        end
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  initial begin : drive_ready
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req > 0) begin
        hold_left = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        hold_left = $urandom_range(0, 6);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      prtb_pkg::CFG_ROW_X: coef_row[0] = data[3*COEF_WIDTH-1:0];
      prtb_pkg::CFG_ROW_Y: coef_row[1] = data[3*COEF_WIDTH-1:0];
      prtb_pkg::CFG_ROW_Z: coef_row[2] = data[3*COEF_WIDTH-1:0];
      prtb_pkg::CFG_OFF_X: offset[0] = data[COORD_WIDTH-1:0];
      prtb_pkg::CFG_OFF_Y: offset[1] = data[COORD_WIDTH-1:0];
      prtb_pkg::CFG_OFF_Z: offset[2] = data[COORD_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic send_point(coord_t px, coord_t py, coord_t pz, logic last);
    in_if.valid <= 1'b1;
    in_if.in_x <= px;
    in_if.in_y <= py;
    in_if.in_z <= pz;
    in_if.cloud_end <= last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predict_point_box(px, py, pz, last);
  endtask

  task automatic maybe_idle();
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (point_box_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0: return coord_t'(COORD_MAX);
      1: return coord_t'(COORD_MIN);
      2, 3: return coord_t'($urandom);
      default: begin
        // within about 16 m of the origin
        v = $urandom_range(0, 2097152);
        return coord_t'(v - 1048576);
      end
    endcase
  endfunction

  function automatic logic [COEF_WIDTH-1:0] rand_coef(int mode);
    int v;
    if (mode == 1) begin
      case ($urandom_range(0, 3))
        0: return COEF_NEG_TWO;
        1: return COEF_TOP;
        2: return '0;
        default: return COEF_ONE;
      endcase
    end
    if (mode == 0 && $urandom_range(0, 1) == 0) return COEF_WIDTH'($urandom);
    v = $urandom_range(0, 2 * COEF_ONE);
    return COEF_WIDTH'(v - COEF_ONE);
  endfunction

  function automatic logic [CFG_W-1:0] rand_offset(int mode);
    int v;
    case (mode)
      1: begin
        case ($urandom_range(0, 2))
          0: return CFG_W'(COORD_MAX);
          1: return CFG_W'(coord_t'(COORD_MIN));
          default: return '0;
        endcase
      end
      0: return CFG_W'({$urandom, $urandom});
      default: begin
        v = $urandom_range(0, 524288);
        return CFG_W'(coord_t'(v - 262144));
      end
    endcase
  endfunction

  task automatic randomize_config(int mode);
    write_reg(prtb_pkg::CFG_ROW_X, {rand_coef(mode), rand_coef(mode), rand_coef(mode)});
    write_reg(prtb_pkg::CFG_ROW_Y, {rand_coef(mode), rand_coef(mode), rand_coef(mode)});
    write_reg(prtb_pkg::CFG_ROW_Z, {rand_coef(mode), rand_coef(mode), rand_coef(mode)});
    write_reg(prtb_pkg::CFG_OFF_X, rand_offset(mode));
    write_reg(prtb_pkg::CFG_OFF_Y, rand_offset(mode));
    write_reg(prtb_pkg::CFG_OFF_Z, rand_offset(mode));
    cfg_we_i <= 1'b0;
  endtask

  // clouds of random length, with a stray end flag now and then
  task automatic send_clouds(int n_points);
    logic last;
    for (int i = 0; i < n_points; i++) begin
      maybe_idle();
      cloud_left--;
      last = (cloud_left == 0) || ($urandom_range(0, 63) == 0);
      if (cloud_left == 0) cloud_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
      send_point(rand_coord(), rand_coord(), rand_coord(), last);
    end
  endtask

  task automatic test_reset_values();
    send_point(0, 0, 0, 1'b0);
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX), 1'b0);
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN), 1'b1);
    // single point cloud
    send_point(coord_t'(COORD_MIN), 0, coord_t'(COORD_MAX), 1'b1);
    send_point(-65536, 65536, 0, 1'b0);
    send_point(1, -1, 2, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_floor_and_saturation();
    write_reg(prtb_pkg::CFG_ROW_X, {16'h0000, 16'h0000, COEF_HALF});
    write_reg(prtb_pkg::CFG_ROW_Y, {COEF_NEG_TWO, COEF_NEG_TWO, COEF_NEG_TWO});
    write_reg(prtb_pkg::CFG_ROW_Z, {COEF_TOP, COEF_TOP, COEF_TOP});
    write_reg(prtb_pkg::CFG_OFF_X, CFG_W'(coord_t'(-1)));
    write_reg(prtb_pkg::CFG_OFF_Y, CFG_W'(COORD_MAX));
    write_reg(prtb_pkg::CFG_OFF_Z, CFG_W'(coord_t'(COORD_MIN)));
    cfg_we_i <= 1'b0;
    // half of -1 rounds down to -1
    send_point(-1, 0, 0, 1'b0);
    send_point(1, 0, 0, 1'b0);
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN), 1'b0);
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX), 1'b1);
    send_point(3, -5, 7, 1'b0);
    send_point(-3, 5, -7, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_register_index_and_width();
    write_reg(CFG_IDX_SPARE_A, '1);
    write_reg(CFG_IDX_SPARE_B, '1);
    write_reg(prtb_pkg::CFG_ROW_X, '1);
    write_reg(prtb_pkg::CFG_ROW_Y, {COEF_ONE, COEF_NEG_TWO, COEF_TOP});
    write_reg(prtb_pkg::CFG_ROW_Z, {16'h0000, COEF_ONE, 16'h0000});
    // upper bits beyond the offset width must be dropped
    write_reg(prtb_pkg::CFG_OFF_X, 48'hFFFF_8000_0001);
    write_reg(prtb_pkg::CFG_OFF_Y, 48'h1234_0000_0010);
    write_reg(prtb_pkg::CFG_OFF_Z, 48'hA5A5_7FFF_FFFF);
    cfg_we_i <= 1'b0;
    send_point(16384, -16384, 65536, 1'b0);
    send_point(coord_t'(COORD_MAX), 0, coord_t'(COORD_MIN), 1'b0);
    send_point(-7, 123456, -98765, 1'b0);
    send_point(0, 0, 0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    randomize_config(2);
    src_idle_on = 1'b0;
    sink_stall_on = 1'b0;
    long_hold_req = 150;
    send_clouds(40);
    wait_results_drained();
  endtask

  task automatic test_source_pause();
    src_idle_on = 1'b1;
    sink_stall_on = 1'b1;
    send_clouds(15);
    // stop offering until the pipeline is empty, config untouched
    wait_results_drained();
    send_clouds(15);
    wait_results_drained();
  endtask

  task automatic test_random_clouds();
    for (int p = 0; p < 12; p++) begin
      src_idle_on = (p < 10);
      sink_stall_on = (p < 10);
      randomize_config(p % 3);
      send_clouds(75);
      wait_results_drained();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= prtb_pkg::CFG_ROW_X;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.in_x <= '0;
    in_if.in_y <= '0;
    in_if.in_z <= '0;
    in_if.cloud_end <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_floor_and_saturation();
    test_register_index_and_width();
    test_backpressure();
    test_source_pause();
    test_random_clouds();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### point_rotate_translate_bbox_core.f
rtl/core/prtb_pkg.sv
rtl/core/prtb_in_if.sv
rtl/core/prtb_out_if.sv
rtl/core/prtb_row.sv
rtl/core/point_rotate_translate_bbox_core.sv
dv/point_rotate_translate_bbox_core_test.sv
